[rtl/csse_pkg.sv]
// Shared types and fixed-point constants for the cubic spline segment evaluator.
`timescale 1ns / 1ps
`default_nettype none

package csse_pkg;

    // Q16.16 sample and coefficient format.
    localparam int Q_W    = 32;
    localparam int FRAC_W = 16;

    // Horner accumulator, full product and rounded product widths.
    localparam int ACC_W  = 64;
    localparam int PROD_W = 96;
    localparam int RND_W  = PROD_W - FRAC_W;

    // Width that holds any interval index plus one.
    localparam int IV_EXT_W = 17;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RND_W-1:0]  rnd_t;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Intermediates are held within +-2^62.
    localparam acc_t ACC_GUARD_POS = 64'sh4000_0000_0000_0000;
    localparam acc_t ACC_GUARD_NEG = 64'shC000_0000_0000_0000;
    localparam rnd_t RND_GUARD_POS = 80'sh0000_4000_0000_0000_0000;
    localparam rnd_t RND_GUARD_NEG = 80'shFFFF_C000_0000_0000_0000;

    // Rounding offsets for half away from zero on a signed product.
    localparam prod_t ROUND_POS = 96'sh8000;
    localparam prod_t ROUND_NEG = 96'sh7FFF;

    // Final Q16.16 range.
    localparam acc_t ACC_Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam acc_t ACC_Q_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam q_t   Q_MAX     = 32'sh7FFF_FFFF;
    localparam q_t   Q_MIN     = 32'sh8000_0000;

endpackage

`default_nettype wire

[rtl/cubic_spline_segment_evaluator.sv]
// Pipelined piecewise polynomial evaluator with a banked coefficient table.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Signals
// ----------+-----+---------------------------------------------------------------
// input     | in  | s_valid s_ready s_cmd s_coef_interval s_coef_order s_coef_value
//           |     | s_x_position s_last_query
// result    | out | m_valid m_ready m_curve_value m_saturated m_last_result
// config    | in  | cfg_valid cfg_ready cfg_wdata (interval count)
//
// One beat is accepted per cycle while s_ready is high; the pipeline has one read stage,
// one setup stage, three stages per Horner step and one output stage.
// A write beat updates the table in the cycle it is accepted and gives no result.
// Reset clears the valid bits and sets the interval count to one; the table is not cleared.
// A stage holds while the stage after it is full and stalled, so bubbles close up.
module cubic_spline_segment_evaluator
    import csse_pkg::*;
#(
    parameter int MAX_INTERVALS = 256,
    parameter int TERMS         = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_coef_interval,
    input  wire logic [1:0]  s_coef_order,
    input  wire logic [31:0] s_coef_value,
    input  wire logic [31:0] s_x_position,
    input  wire logic        s_last_query,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_curve_value,
    output logic             m_saturated,
    output logic             m_last_result
);

    localparam int IDX_W    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int LAST_MAX = MAX_INTERVALS - 1;
    localparam int STEPS    = TERMS - 1;
    localparam int DEPTH    = 3 * TERMS;
    localparam int S_OUT    = DEPTH - 1;

    // ------------------------------------------------------------------
    // Configuration: keep the clamped last interval index.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]    last_iv_reg;
    logic [IDX_W-1:0]    last_iv_next;
    logic [IV_EXT_W-1:0] cfg_ext;

    assign cfg_ready = 1'b1;
    assign cfg_ext   = IV_EXT_W'(cfg_wdata);

    always_comb begin
        if (cfg_wdata == 9'd0) begin
            last_iv_next = '0;
        end else if (cfg_ext > IV_EXT_W'(MAX_INTERVALS)) begin
            last_iv_next = IDX_W'(LAST_MAX);
        end else begin
            last_iv_next = IDX_W'(cfg_ext - IV_EXT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_iv_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            last_iv_reg <= last_iv_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and valid bits.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH:0]   adv;
    logic             in_acc;
    logic             eval_acc;
    logic             wr_acc;

    assign adv[DEPTH] = m_ready;
    for (genvar s = 0; s < DEPTH; s++) begin : g_adv
        assign adv[s] = !valid_reg[s] || adv[s+1];
    end

    assign s_ready  = adv[0];
    assign in_acc   = s_valid && s_ready;
    assign eval_acc = in_acc && (s_cmd == CMD_EVAL);
    assign wr_acc   = in_acc && (s_cmd == CMD_WRITE);

    always_comb begin
        valid_next[0] = adv[0] ? eval_acc : valid_reg[0];
        for (int s = 1; s < DEPTH; s++) begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: interval lookup and coefficient table, one bank per order.
    // ------------------------------------------------------------------
    logic [15:0]          x_hi;
    logic [IV_EXT_W-1:0]  x_hi_ext;
    logic [IV_EXT_W-1:0]  last_ext;
    logic [IDX_W-1:0]     rd_addr;
    logic [IV_EXT_W-1:0]  wr_iv_ext;
    logic                 wr_in_range;
    logic [IDX_W-1:0]     wr_addr;
    q_t                   rd_data_reg [TERMS];
    q_t                   x0_reg;
    logic [IDX_W-1:0]     iv0_reg;
    logic                 last0_reg;

    assign x_hi     = s_x_position[31:16];
    assign x_hi_ext = IV_EXT_W'(x_hi);
    assign last_ext = IV_EXT_W'(last_iv_reg);

    // Floor of the position, clamped to the intervals in use.
    always_comb begin
        if (x_hi[15]) begin
            rd_addr = '0;
        end else if (x_hi_ext > last_ext) begin
            rd_addr = last_iv_reg;
        end else begin
            rd_addr = IDX_W'(x_hi);
        end
    end

    assign wr_iv_ext   = IV_EXT_W'(s_coef_interval);
    assign wr_in_range = wr_iv_ext < IV_EXT_W'(MAX_INTERVALS);
    assign wr_addr     = IDX_W'(wr_iv_ext);

    for (genvar k = 0; k < TERMS; k++) begin : g_bank
        logic [31:0] coef_mem [MAX_INTERVALS];

        always_ff @(posedge aclk) begin
            if (wr_acc && wr_in_range && (4'(s_coef_order) == 4'(k))) begin
                coef_mem[wr_addr] <= s_coef_value;
            end
            if (eval_acc) begin
                rd_data_reg[k] <= coef_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x0_reg    <= s_x_position;
            iv0_reg   <= rd_addr;
            last0_reg <= s_last_query;
        end
    end

    // ------------------------------------------------------------------
    // Side data that travels with each item: flag, offset t, coefficients.
    // ------------------------------------------------------------------
    logic last_reg [1:DEPTH-1];
    q_t   t_reg    [1:DEPTH-1];
    q_t   coef_reg [1:DEPTH-1][TERMS];
    acc_t acc_reg  [TERMS];
    q_t   t_next;
    logic [15:0] t_hi;

    // Offset within the interval; its integer part always fits 16 bits.
    assign t_hi   = x0_reg[31:16] - 16'(iv0_reg);
    assign t_next = {t_hi, x0_reg[15:0]};

    for (genvar s = 1; s < DEPTH; s++) begin : g_side
        if (s == 1) begin : g_first
            always_ff @(posedge aclk) begin
                if (adv[1]) begin
                    last_reg[1] <= last0_reg;
                    t_reg[1]    <= t_next;
                    coef_reg[1] <= rd_data_reg;
                    acc_reg[0]  <= ACC_W'(rd_data_reg[TERMS-1]);
                end
            end
        end else begin : g_copy
            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    last_reg[s] <= last_reg[s-1];
                    t_reg[s]    <= t_reg[s-1];
                    coef_reg[s] <= coef_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner steps: multiply, round, add coefficient. Three stages each.
    // ------------------------------------------------------------------
    logic signed [64:0] pl_reg  [STEPS];
    logic signed [63:0] ph_reg  [STEPS];
    logic               neg_reg [STEPS];
    rnd_t               r_reg   [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int SM = 2 + 3 * j;
        localparam int SR = SM + 1;
        localparam int SA = SM + 2;
        localparam int KC = TERMS - 2 - j;

        prod_t sum_next;
        rnd_t  r_next;
        acc_t  rc_next;
        acc_t  s_next;
        acc_t  acc_next;

        // The accumulator is split into an unsigned low and a signed high half.
        always_ff @(posedge aclk) begin
            if (adv[SM]) begin
                pl_reg[j]  <= $signed({1'b0, acc_reg[j][31:0]}) * $signed(t_reg[SM-1]);
                ph_reg[j]  <= $signed(acc_reg[j][63:32]) * $signed(t_reg[SM-1]);
                neg_reg[j] <= acc_reg[j][ACC_W-1] ^ t_reg[SM-1][Q_W-1];
            end
        end

        // A negative product rounds with one less, which gives half away from zero.
        always_comb begin
            sum_next = $signed({ph_reg[j], 32'h0})
                     + $signed({{31{pl_reg[j][64]}}, pl_reg[j]})
                     + (neg_reg[j] ? ROUND_NEG : ROUND_POS);
            r_next   = sum_next[PROD_W-1:FRAC_W];
        end

        always_ff @(posedge aclk) begin
            if (adv[SR]) begin
                r_reg[j] <= r_next;
            end
        end

        always_comb begin
            if (r_reg[j] > RND_GUARD_POS) begin
                rc_next = ACC_GUARD_POS;
            end else if (r_reg[j] < RND_GUARD_NEG) begin
                rc_next = ACC_GUARD_NEG;
            end else begin
                rc_next = r_reg[j][ACC_W-1:0];
            end
            s_next = rc_next + ACC_W'(coef_reg[SA-1][KC]);
            if (s_next > ACC_GUARD_POS) begin
                acc_next = ACC_GUARD_POS;
            end else if (s_next < ACC_GUARD_NEG) begin
                acc_next = ACC_GUARD_NEG;
            end else begin
                acc_next = s_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[SA]) begin
                acc_reg[j+1] <= acc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturate to Q16.16.
    // ------------------------------------------------------------------
    q_t   value_next;
    logic sat_next;
    q_t   value_reg;
    logic sat_reg;

    always_comb begin
        if (acc_reg[STEPS] > ACC_Q_MAX) begin
            value_next = Q_MAX;
            sat_next   = 1'b1;
        end else if (acc_reg[STEPS] < ACC_Q_MIN) begin
            value_next = Q_MIN;
            sat_next   = 1'b1;
        end else begin
            value_next = acc_reg[STEPS][Q_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S_OUT]) begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_valid        = valid_reg[S_OUT];
    assign m_curve_value  = value_reg;
    assign m_saturated    = sat_reg;
    assign m_last_result  = last_reg[S_OUT];

`ifndef SYNTH
    // A write beat never starts an item down the pipeline.
    a_write_no_item: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_acc |=> !valid_reg[0])
        else $error("write beat entered the pipeline");

    // The table is never read beyond the intervals in use.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_acc |-> (IV_EXT_W'(rd_addr) <= last_ext))
        else $error("table read beyond last interval");

    // The final accumulator stays inside the guard range.
    a_acc_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[S_OUT-1] |-> (acc_reg[STEPS] <= ACC_GUARD_POS)
                            && (acc_reg[STEPS] >= ACC_GUARD_NEG))
        else $error("accumulator outside guard range");

    // A flagged result sits at one end of the range.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_curve_value == Q_MAX) || (m_curve_value == Q_MIN))
        else $error("saturated flag without clipped value");

    // An empty pipeline always takes a beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg == '0) |-> s_ready)
        else $error("empty pipeline not ready");
`endif

endmodule

`default_nettype wire

[tb/csse_checker.sv]
// Scoreboard for the spline evaluator: tracks the coefficient table and checks every result beat.
`timescale 1ns / 1ps

module csse_checker
    import csse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [8:0]  cfg_wdata,

    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_coef_interval,
    input  wire logic [1:0]  s_coef_order,
    input  wire logic [31:0] s_coef_value,
    input  wire logic [31:0] s_x_position,
    input  wire logic        s_last_query,

    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_curve_value,
    input  wire logic        m_saturated,
    input  wire logic        m_last_result,

    output int               fail_count,
    output int               pending,
    output int               checked,
    output int               sat_count
);

    localparam int SPANS  = 256;
    localparam int ORDERS = 4;

    typedef struct packed {
        q_t   value;
        logic sat;
        logic last;
    } spline_result_t;

    q_t             coef_mem [SPANS*ORDERS];
    logic [8:0]     span_reg;
    spline_result_t expected_results [$];

    // Exact product of a Q16.16 accumulator and t, rounded half away from zero
    // and held within the +-2^62 guard band.
    function automatic acc_t round_mul_q16(input acc_t a, input acc_t b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic [127:0]        prod;
        logic [127:0]        quo;
        logic                neg;
        acc_t                mag;
        wa   = a;
        wb   = b;
        neg  = (a < 0) != (b < 0);
        prod = (wa < 0 ? -wa : wa) * (wb < 0 ? -wb : wb);
        quo  = (prod + 128'h8000) >> 16;
        if (quo > 128'(ACC_GUARD_POS)) begin
            mag = ACC_GUARD_POS;
        end else begin
            mag = quo[63:0];
        end
        return neg ? -mag : mag;
    endfunction

    function automatic spline_result_t eval_spline(input q_t x, input logic last);
        int             n;
        int             span;
        acc_t           t;
        acc_t           acc;
        spline_result_t r;
        n = span_reg;
        if (n < 1) n = 1;
        if (n > SPANS) n = SPANS;
        span = x >>> FRAC_W;
        if (span < 0) span = 0;
        if (span > n - 1) span = n - 1;
        t   = acc_t'(x) - (acc_t'(span) <<< FRAC_W);
        acc = coef_mem[span*ORDERS + ORDERS - 1];
        for (int k = ORDERS - 2; k >= 0; k--) begin
            acc = round_mul_q16(acc, t) + coef_mem[span*ORDERS + k];
            if (acc > ACC_GUARD_POS) acc = ACC_GUARD_POS;
            if (acc < ACC_GUARD_NEG) acc = ACC_GUARD_NEG;
        end
        r.sat = 1'b0;
        if (acc > ACC_Q_MAX) begin
            acc   = ACC_Q_MAX;
            r.sat = 1'b1;
        end
        if (acc < ACC_Q_MIN) begin
            acc   = ACC_Q_MIN;
            r.sat = 1'b1;
        end
        r.value = acc[31:0];
        r.last  = last;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        spline_result_t exp_r;
        if (!aresetn) begin
            span_reg = 9'd1;
            expected_results.delete();
            fail_count = 0;
            checked    = 0;
            sat_count  = 0;
        end else begin
            // The result side is handled first; a result never belongs to an
            // input beat taken on the same edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result beat with nothing pending: curve_value %h", m_curve_value);
                end else begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (exp_r.sat) sat_count++;
                    if (m_curve_value !== exp_r.value) begin
                        fail_count++;
                        $error("curve_value: expected %h, actual %h",
                               exp_r.value, m_curve_value);
                    end
                    if (m_saturated !== exp_r.sat) begin
                        fail_count++;
                        $error("saturated: expected %b, actual %b", exp_r.sat, m_saturated);
                    end
                    if (m_last_result !== exp_r.last) begin
                        fail_count++;
                        $error("last_result: expected %b, actual %b",
                               exp_r.last, m_last_result);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                span_reg = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_WRITE) begin
                    coef_mem[{s_coef_interval, s_coef_order}] = s_coef_value;
                end else begin
                    expected_results.push_back(eval_spline(s_x_position, s_last_query));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/tb_cubic_spline_segment_evaluator.sv]
// Testbench top for the spline evaluator: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_cubic_spline_segment_evaluator;
    import csse_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int PHASES          = 7;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_wdata       = 9'd0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_cmd           = CMD_WRITE;
    logic [7:0]  s_coef_interval = 8'd0;
    logic [1:0]  s_coef_order    = 2'd0;
    logic [31:0] s_coef_value    = 32'd0;
    logic [31:0] s_x_position    = 32'd0;
    logic        s_last_query    = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_curve_value;
    logic        m_saturated;
    logic        m_last_result;

    int fail_count;
    int pending;
    int checked;
    int sat_count;

    // Stimulus-side bookkeeping so that no evaluation lands on an unwritten row.
    logic [3:0] written [256];
    int         eff_spans     = 1;
    int         write_count   = 0;
    int         eval_count    = 0;
    int         setting_count = 0;
    bit         send_idle_on  = 1'b1;
    bit         recv_idle_on  = 1'b1;
    bit         hold_req      = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    cubic_spline_segment_evaluator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_coef_interval (s_coef_interval),
        .s_coef_order    (s_coef_order),
        .s_coef_value    (s_coef_value),
        .s_x_position    (s_x_position),
        .s_last_query    (s_last_query),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_curve_value   (m_curve_value),
        .m_saturated     (m_saturated),
        .m_last_result   (m_last_result)
    );

    csse_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_coef_interval (s_coef_interval),
        .s_coef_order    (s_coef_order),
        .s_coef_value    (s_coef_value),
        .s_x_position    (s_x_position),
        .s_last_query    (s_last_query),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_curve_value   (m_curve_value),
        .m_saturated     (m_saturated),
        .m_last_result   (m_last_result),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked),
        .sat_count       (sat_count)
    );

    // Result-side ready: random stall bursts, plus one long hold-off on request.
    always begin : result_ready_gen
        int hold_left;
        @(negedge aclk);
        if (hold_req) begin
            m_ready   <= 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
                @(negedge aclk);
                hold_left--;
            end
            hold_req = 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge aclk);
        end else begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20) - 1) @(negedge aclk);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL cubic_spline_segment_evaluator");
        $finish;
    end

    // Mostly modest magnitudes so results stay in range; the rest use all 32 bits.
    function automatic q_t coef_draw();
        q_t v;
        v = $urandom;
        if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(6, 28);
        return v;
    endfunction

    function automatic int target_span(input q_t x);
        int span;
        span = x >>> FRAC_W;
        if (span < 0) span = 0;
        if (span > eff_spans - 1) span = eff_spans - 1;
        return span;
    endfunction

    task automatic send_beat(input logic cmd, input logic [7:0] iv, input logic [1:0] ord,
                             input q_t val, input q_t x, input logic last);
        int gap;
        if (send_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_coef_interval <= iv;
        s_coef_order    <= ord;
        s_coef_value    <= val;
        s_x_position    <= x;
        s_last_query    <= last;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_WRITE) begin
            written[iv][ord] = 1'b1;
            write_count++;
        end else begin
            eval_count++;
        end
    endtask

    task automatic write_coef(input logic [7:0] iv, input logic [1:0] ord, input q_t val);
        send_beat(CMD_WRITE, iv, ord, val, $urandom, 1'($urandom));
    endtask

    task automatic eval_at(input q_t x, input logic last);
        send_beat(CMD_EVAL, 8'($urandom), 2'($urandom), $urandom, x, last);
    endtask

    // Waits until every result is out and the pipeline has emptied, then
    // returns; set_span_count calls it before it writes the interval count.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_span_count(input logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        eff_spans = (v == 0) ? 1 : (v > 256) ? 256 : v;
        setting_count++;
    endtask

    initial begin : stimulus
        logic [8:0] phase_setting [PHASES];
        int         iv;
        int         span;
        int         mode;
        int         d;
        logic [1:0] ord;
        q_t         x;
        foreach (written[i]) written[i] = 4'h0;
        phase_setting = '{9'd1, 9'd256, 9'd0, 9'($urandom_range(2, 255)), 9'd511,
                          9'($urandom_range(257, 510)), 9'd256};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a zero count acting as one, rounding on exact halves, both
        // extrapolation ends, the coefficient extremes and over-range counts.
        set_span_count(9'd0);
        write_coef(8'd0, 2'd0, 32'sh0001_0000);
        write_coef(8'd0, 2'd1, 32'shFFFF_0000);
        write_coef(8'd0, 2'd2, 32'sh0000_0001);
        write_coef(8'd0, 2'd3, 32'sh0000_8000);
        eval_at(32'sh0000_0000, 1'b0);
        eval_at(32'sh0000_8000, 1'b0);
        eval_at(32'shFFFF_FFFF, 1'b0);
        eval_at(32'sh8000_0000, 1'b1);
        eval_at(32'sh7FFF_FFFF, 1'b1);
        write_coef(8'd255, 2'd0, 32'sh7FFF_FFFF);
        write_coef(8'd255, 2'd1, 32'sh8000_0000);
        write_coef(8'd255, 2'd2, 32'sh7FFF_FFFF);
        write_coef(8'd255, 2'd3, 32'sh8000_0000);
        set_span_count(9'd511);
        eval_at(32'sh00FF_8000, 1'b0);
        eval_at(32'sh7FFF_FFFF, 1'b0);
        eval_at(32'sh8000_0000, 1'b1);
        eval_at(32'sh00FF_0000, 1'b0);
        set_span_count(9'd256);
        eval_at(32'sh7FFF_FFFF, 1'b1);
        eval_at(32'sh0100_0000, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            set_span_count(phase_setting[p]);
            send_idle_on = (p != PHASES - 1);
            recv_idle_on = (p != PHASES - 1);
            if (p == 1) begin
                // Keep offering beats while the result side is held off.
                send_idle_on = 1'b0;
                hold_req     = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 35) begin
                    iv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, eff_spans - 1);
                    write_coef(8'(iv), 2'($urandom), coef_draw());
                end else begin
                    mode = $urandom_range(0, 9);
                    if (mode < 6) begin
                        x = (int'($urandom_range(0, eff_spans - 1)) << 16)
                            | int'($urandom_range(0, 65535));
                    end else if (mode < 8) begin
                        x = $urandom;
                    end else if (mode == 8) begin
                        x = ((eff_spans - 1 + int'($urandom_range(1, 40))) << 16)
                            | int'($urandom_range(0, 65535));
                    end else begin
                        d = $urandom_range(1, 40 * 65536);
                        x = -d;
                    end
                    span = target_span(x);
                    if (written[span] == 4'hF) begin
                        eval_at(x, $urandom_range(0, 3) == 0);
                    end else begin
                        // Fill in the lowest missing coefficient of that row instead.
                        ord = 2'd0;
                        for (int k = 3; k >= 0; k--) begin
                            if (!written[span][k]) ord = 2'(k);
                        end
                        write_coef(8'(span), ord, coef_draw());
                    end
                end
            end
        end

        drain();
        $display("Run covered %0d coefficient writes and %0d evaluations over %0d count settings.",
                 write_count, eval_count, setting_count);
        $display("Scoreboard compared %0d results, %0d of them clipped to the Q16.16 range.",
                 checked, sat_count);
        if (fail_count == 0) begin
            $display("PASS cubic_spline_segment_evaluator");
        end else begin
            $display("FAIL cubic_spline_segment_evaluator");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/csse_pkg.sv
rtl/cubic_spline_segment_evaluator.sv
tb/csse_checker.sv
tb/tb_cubic_spline_segment_evaluator.sv
